// File: rtl/drbf_pkg.sv
// Shared types and constants of the backlight reveal and fade sequencer.
// Depends on nothing; every other file imports it.
package drbf_pkg;

  localparam int ACTION_W = 4;
  localparam int LEVEL_W  = 8;
  localparam int FADE_W   = 10;
  localparam int MS_W     = 16;
  localparam int CUBE_W   = 3 * FADE_W;
  localparam int PROD_W   = CUBE_W + FADE_W;
  localparam int SCALE_W  = CUBE_W + LEVEL_W;
  localparam int NUM_W    = SCALE_W + 2;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam logic [ACTION_W-1:0] ACT_TICK      = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_LIGHT_ON  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_LIGHT_OFF = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_SET_LEVEL = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_REVEAL    = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE  = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_BOOT      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_DEFER     = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_BATCH_ON  = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_BATCH_OFF = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_CLR_HOST  = 4'd10;

  localparam logic [2:0] REG_FADE     = 3'd0;
  localparam logic [2:0] REG_HOLD     = 3'd1;
  localparam logic [2:0] REG_BOOT     = 3'd2;
  localparam logic [2:0] REG_COALESCE = 3'd3;
  localparam logic [2:0] REG_FALLBACK = 3'd4;
  localparam logic [2:0] REG_RETRY    = 3'd5;
  localparam logic [2:0] REG_MIN_BRI  = 3'd6;

  localparam logic [FADE_W-1:0]  FADE_RST     = 10'd160;
  localparam logic [MS_W-1:0]    HOLD_RST     = 16'd280;
  localparam logic [MS_W-1:0]    BOOT_RST     = 16'd800;
  localparam logic [MS_W-1:0]    COALESCE_RST = 16'd350;
  localparam logic [MS_W-1:0]    FALLBACK_RST = 16'd2500;
  localparam logic [MS_W-1:0]    RETRY_RST    = 16'd50;
  localparam logic [LEVEL_W-1:0] MIN_BRI_RST  = 8'd8;
  localparam logic [LEVEL_W-1:0] LEVEL_RST    = 8'd255;

  // Steps of the shared multiplier.
  localparam logic [2:0] MUL_FF   = 3'd0;
  localparam logic [2:0] MUL_FFF  = 3'd1;
  localparam logic [2:0] MUL_QQ   = 3'd2;
  localparam logic [2:0] MUL_QQQ  = 3'd3;
  localparam logic [2:0] MUL_SCALE = 3'd4;

  typedef struct packed {
    logic [FADE_W-1:0]  fade_ms;
    logic [MS_W-1:0]    hold_ms;
    logic [MS_W-1:0]    boot_ms;
    logic [MS_W-1:0]    coalesce_ms;
    logic [MS_W-1:0]    fallback_ms;
    logic [MS_W-1:0]    retry_ms;
    logic [LEVEL_W-1:0] min_bri;
  } cfg_t;

  typedef struct packed {
    logic       exec;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       div_init;
    logic       div_en;
    logic [2:0] div_bit;
    logic       duty_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic calc;
  } sts_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_duty;
    logic               defer_blit;
    logic               redraw_all;
    logic               fading_now;
    logic               batch_mode;
    logic [LEVEL_W-1:0] brightness;
  } res_t;

endpackage

// File: rtl/drbf_chan_if.sv
// Valid/ready channel interfaces for the item and result streams.
// Depends on drbf_pkg for the field widths.
interface drbf_in_if;
  import drbf_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LEVEL_W-1:0]  level_in;
  logic                frame_rx_busy;
  modport source (output valid, action, level_in, frame_rx_busy, input ready);
  modport sink (input valid, action, level_in, frame_rx_busy, output ready);
endinterface

interface drbf_out_if;
  import drbf_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pwm_duty;
  logic               defer_blit;
  logic               redraw_all;
  logic               fading_now;
  logic               batch_mode;
  logic [LEVEL_W-1:0] brightness;
  modport source (output valid, pwm_duty, defer_blit, redraw_all, fading_now, batch_mode,
                  brightness, input ready);
  modport sink (input valid, pwm_duty, defer_blit, redraw_all, fading_now, batch_mode,
                brightness, output ready);
endinterface

// File: rtl/drbf_cfg.sv
// APB-style configuration register file of the fader.
// Depends on drbf_pkg for the register map and the cfg_t bundle.
module drbf_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drbf_pkg::APB_AW-1:0]    paddr,
  input  logic [drbf_pkg::APB_DW-1:0]    pwdata,
  output logic [drbf_pkg::APB_DW-1:0]    prdata,
  output drbf_pkg::cfg_t                 cfg
);
  import drbf_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[APB_AW-1:2];
  assign wr  = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_FADE:     cfg_nxt.fade_ms     = pwdata[FADE_W-1:0];
        REG_HOLD:     cfg_nxt.hold_ms     = pwdata[MS_W-1:0];
        REG_BOOT:     cfg_nxt.boot_ms     = pwdata[MS_W-1:0];
        REG_COALESCE: cfg_nxt.coalesce_ms = pwdata[MS_W-1:0];
        REG_FALLBACK: cfg_nxt.fallback_ms = pwdata[MS_W-1:0];
        REG_RETRY:    cfg_nxt.retry_ms    = pwdata[MS_W-1:0];
        REG_MIN_BRI:  cfg_nxt.min_bri     = pwdata[LEVEL_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FADE:     prdata = APB_DW'(cfg_r.fade_ms);
      REG_HOLD:     prdata = APB_DW'(cfg_r.hold_ms);
      REG_BOOT:     prdata = APB_DW'(cfg_r.boot_ms);
      REG_COALESCE: prdata = APB_DW'(cfg_r.coalesce_ms);
      REG_FALLBACK: prdata = APB_DW'(cfg_r.fallback_ms);
      REG_RETRY:    prdata = APB_DW'(cfg_r.retry_ms);
      REG_MIN_BRI:  prdata = APB_DW'(cfg_r.min_bri);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_ms     <= FADE_RST;
      cfg_r.hold_ms     <= HOLD_RST;
      cfg_r.boot_ms     <= BOOT_RST;
      cfg_r.coalesce_ms <= COALESCE_RST;
      cfg_r.fallback_ms <= FALLBACK_RST;
      cfg_r.retry_ms    <= RETRY_RST;
      cfg_r.min_bri     <= MIN_BRI_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/drbf_ctrl.sv
// Sequencer of the fader: handshakes, multiplier steps and divider steps.
// Depends on drbf_pkg for the command and status bundles.
module drbf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  drbf_pkg::sts_t sts,
  output drbf_pkg::cmd_t cmd
);
  import drbf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mul_sel  = cnt_r;
    cmd.div_bit  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          cnt_nxt   = MUL_FF;
          state_nxt = sts.calc ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt_r == MUL_SCALE) begin
          state_nxt = S_DINIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = 3'd7;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      S_FIN: begin
        cmd.duty_load = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/drbf_dp.sv
// Datapath of the fader: time and event state, shared multiplier,
// restoring divider for the ease-out curve and the result register.
// Depends on drbf_pkg.
module drbf_dp #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [drbf_pkg::ACTION_W-1:0] action,
  input  logic [drbf_pkg::LEVEL_W-1:0]  level_in,
  input  logic                          frame_rx_busy,
  input  drbf_pkg::cfg_t                cfg,
  input  drbf_pkg::cmd_t                cmd,
  output drbf_pkg::sts_t                sts,
  output drbf_pkg::res_t                res
);
  import drbf_pkg::*;

  localparam int TB = TIME_BITS;

  logic [TB-1:0]      now_r, now_nxt;
  logic [TB-1:0]      fstart_r, fstart_nxt;
  logic [TB-1:0]      hold_r, hold_nxt;
  logic [TB-1:0]      ready_at_r, ready_at_nxt;
  logic [TB-1:0]      bsince_r, bsince_nxt;
  logic [LEVEL_W-1:0] target_r, target_nxt;
  logic [LEVEL_W-1:0] duty_r, duty_nxt;
  logic               light_r, light_nxt;
  logic               fading_r, fading_nxt;
  logic               pend_r, pend_nxt;
  logic               host_r, host_nxt;
  logic               batch_r, batch_nxt;
  logic               redrew_r, redrew_nxt;
  logic [FADE_W-1:0]  q_r, q_nxt;
  logic               calc;

  logic [TB-1:0]      now1, dready, dbatch, tel;
  logic [LEVEL_W-1:0] lvl;

  logic [CUBE_W-1:0]  m_r;
  logic [CUBE_W-1:0]  f3_r;
  logic [SCALE_W-1:0] p_r;
  logic [NUM_W-1:0]   num_r;
  logic [LEVEL_W-1:0] quo_r;
  logic [CUBE_W-1:0]  mul_a;
  logic [FADE_W-1:0]  mul_b;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   trial;
  logic [TB-1:0]      dhold;
  res_t               res_r;

  assign now1   = now_r + TB'(1);
  assign dready = now1 - ready_at_r;
  assign dbatch = now1 - bsince_r;
  assign sts.calc = calc;
  assign res    = res_r;

  always_comb begin
    now_nxt      = now_r;
    fstart_nxt   = fstart_r;
    hold_nxt     = hold_r;
    ready_at_nxt = ready_at_r;
    bsince_nxt   = bsince_r;
    target_nxt   = target_r;
    duty_nxt     = duty_r;
    light_nxt    = light_r;
    fading_nxt   = fading_r;
    pend_nxt     = pend_r;
    host_nxt     = host_r;
    batch_nxt    = batch_r;
    redrew_nxt   = 1'b0;
    q_nxt        = q_r;
    calc         = 1'b0;
    tel          = '0;
    lvl          = (level_in < cfg.min_bri) ? cfg.min_bri : level_in;
    unique case (action)
      ACT_TICK: begin
        now_nxt = now1;
        if (pend_r && !dready[TB-1]) begin
          if (frame_rx_busy) begin
            ready_at_nxt = now1 + TB'(cfg.retry_ms);
          end else begin
            pend_nxt   = 1'b0;
            batch_nxt  = 1'b0;
            duty_nxt   = '0;
            hold_nxt   = now1 + TB'(cfg.hold_ms);
            fstart_nxt = now1;
            fading_nxt = 1'b1;
            light_nxt  = 1'b1;
            redrew_nxt = 1'b1;
          end
        end
        if (host_r && batch_nxt && !pend_nxt && !dbatch[TB-1] &&
            dbatch >= TB'(cfg.fallback_ms)) begin
          host_nxt   = 1'b0;
          batch_nxt  = 1'b0;
          duty_nxt   = '0;
          hold_nxt   = now1 + TB'(cfg.hold_ms);
          fstart_nxt = now1;
          fading_nxt = 1'b1;
          light_nxt  = 1'b1;
          redrew_nxt = 1'b1;
        end
        if (fading_nxt) begin
          tel = now1 - fstart_nxt;
          if (tel >= TB'(cfg.fade_ms)) begin
            duty_nxt   = target_r;
            fading_nxt = 1'b0;
          end else begin
            calc  = 1'b1;
            q_nxt = cfg.fade_ms - tel[FADE_W-1:0];
          end
        end
      end
      ACT_LIGHT_ON: begin
        light_nxt = 1'b1;
        duty_nxt  = target_r;
      end
      ACT_LIGHT_OFF: begin
        fading_nxt = 1'b0;
        light_nxt  = 1'b0;
        duty_nxt   = '0;
      end
      ACT_SET_LEVEL: begin
        target_nxt = lvl;
        if (light_r && !fading_r) begin
          duty_nxt = lvl;
        end
      end
      ACT_REVEAL: begin
        duty_nxt   = '0;
        hold_nxt   = now_r + TB'(cfg.hold_ms);
        fstart_nxt = now_r;
        fading_nxt = 1'b1;
        light_nxt  = 1'b1;
        redrew_nxt = 1'b1;
      end
      ACT_SCHEDULE: begin
        pend_nxt     = 1'b1;
        ready_at_nxt = now_r + TB'(cfg.coalesce_ms);
      end
      ACT_BOOT: begin
        if (!host_r) begin
          pend_nxt     = 1'b1;
          ready_at_nxt = now_r + TB'(cfg.boot_ms);
        end
      end
      ACT_DEFER: begin
        if (!host_r) begin
          host_nxt   = 1'b1;
          pend_nxt   = 1'b0;
          fading_nxt = 1'b0;
          light_nxt  = 1'b0;
          duty_nxt   = '0;
        end
      end
      ACT_BATCH_ON: begin
        batch_nxt  = 1'b1;
        bsince_nxt = now_r;
      end
      ACT_BATCH_OFF: batch_nxt = 1'b0;
      ACT_CLR_HOST: begin
        host_nxt  = 1'b0;
        batch_nxt = 1'b0;
      end
      default: redrew_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      fstart_r   <= '0;
      hold_r     <= '0;
      ready_at_r <= '0;
      bsince_r   <= '0;
      target_r   <= LEVEL_RST;
      duty_r     <= '0;
      light_r    <= 1'b0;
      fading_r   <= 1'b0;
      pend_r     <= 1'b0;
      host_r     <= 1'b0;
      batch_r    <= 1'b0;
      redrew_r   <= 1'b0;
    end else if (cmd.exec) begin
      now_r      <= now_nxt;
      fstart_r   <= fstart_nxt;
      hold_r     <= hold_nxt;
      ready_at_r <= ready_at_nxt;
      bsince_r   <= bsince_nxt;
      target_r   <= target_nxt;
      duty_r     <= duty_nxt;
      light_r    <= light_nxt;
      fading_r   <= fading_nxt;
      pend_r     <= pend_nxt;
      host_r     <= host_nxt;
      batch_r    <= batch_nxt;
      redrew_r   <= redrew_nxt;
    end else if (cmd.duty_load) begin
      duty_r <= quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      q_r <= q_nxt;
    end
  end

  // Cubes of the fade length and of the remaining time, then the scaled difference.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_FF: begin
        mul_a = CUBE_W'(cfg.fade_ms);
        mul_b = cfg.fade_ms;
      end
      MUL_FFF: begin
        mul_a = m_r;
        mul_b = cfg.fade_ms;
      end
      MUL_QQ: begin
        mul_a = CUBE_W'(q_r);
        mul_b = q_r;
      end
      MUL_QQQ: begin
        mul_a = m_r;
        mul_b = q_r;
      end
      MUL_SCALE: begin
        mul_a = f3_r - m_r;
        mul_b = FADE_W'(target_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign trial = {{(NUM_W-CUBE_W-1){1'b0}}, f3_r, 1'b0} << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_FF, MUL_QQ, MUL_QQQ: m_r <= prod[CUBE_W-1:0];
        MUL_FFF:                 f3_r <= prod[CUBE_W-1:0];
        MUL_SCALE:               p_r <= prod[SCALE_W-1:0];
        default:                 m_r <= m_r;
      endcase
    end
    if (cmd.div_init) begin
      num_r <= {1'b0, p_r, 1'b0} + NUM_W'(f3_r);
      quo_r <= '0;
    end else if (cmd.div_en) begin
      if (num_r >= trial) begin
        num_r <= num_r - trial;
        quo_r[cmd.div_bit] <= 1'b1;
      end
    end
  end

  assign dhold = now_r - hold_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r.pwm_duty   <= duty_r;
      res_r.defer_blit <= batch_r || pend_r || dhold[TB-1];
      res_r.redraw_all <= redrew_r;
      res_r.fading_now <= fading_r;
      res_r.batch_mode <= batch_r;
      res_r.brightness <= target_r;
    end
  end

endmodule

// File: rtl/display_reveal_backlight_fader_unit.sv
// Backlight reveal and fade sequencer, top level.
// An item that needs no curve point goes from acceptance straight to the result stage; a
// tick that needs one first runs five steps of the one shared multiplier, S_DINIT, eight
// steps of the restoring divider and S_FIN. A result is loaded once the output register
// is free; the next item is accepted in the cycle after a result is loaded. A synchronous
// low rst_n restores control, time and event state and the registers to their defaults.
module display_reveal_backlight_fader_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  drbf_in_if.sink                       in_if,
  drbf_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [drbf_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [drbf_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [drbf_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import drbf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  res_t res;

  assign cfg_pready = 1'b1;

  drbf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  drbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  drbf_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .action        (in_if.action),
    .level_in      (in_if.level_in),
    .frame_rx_busy (in_if.frame_rx_busy),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .res           (res)
  );

  assign out_if.pwm_duty   = res.pwm_duty;
  assign out_if.defer_blit = res.defer_blit;
  assign out_if.redraw_all = res.redraw_all;
  assign out_if.fading_now = res.fading_now;
  assign out_if.batch_mode = res.batch_mode;
  assign out_if.brightness = res.brightness;

endmodule

// File: rtl/drbf_checker.sv
// Port-level assertions for the fader and the bind that attaches them.
// Depends on drbf_pkg and on the top level's ports.
module drbf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [drbf_pkg::LEVEL_W-1:0] pwm_duty,
  input logic [drbf_pkg::LEVEL_W-1:0] brightness,
  input logic                         defer_blit,
  input logic                         batch_mode
);
  import drbf_pkg::*;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("a second item was offered acceptance straight after one was taken");

  a_batch_defers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && batch_mode |-> defer_blit)
    else $error("host batch reported without deferred blits");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_payload_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pwm_duty) && $stable(brightness))
    else $error("stalled result changed");

endmodule

bind display_reveal_backlight_fader_unit drbf_checker u_drbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .pwm_duty   (out_if.pwm_duty),
  .brightness (out_if.brightness),
  .defer_blit (out_if.defer_blit),
  .batch_mode (out_if.batch_mode)
);

// File: bench/tb_display_reveal_backlight_fader_unit.sv
// Self-checking testbench of the backlight reveal and fade sequencer.
// Needs drbf_pkg, the channel interfaces and display_reveal_backlight_fader_unit; a local
// model of the sequencer predicts all but typed rows' results, compared field by field.
`timescale 1ns / 100ps

module tb_display_reveal_backlight_fader_unit;
  import drbf_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACT_CLR_HOST + 4'd1;
  localparam logic [ACTION_W-1:0] ACT_LAST_CODE    = '1;
  localparam int                  NUM_REGS         = 7;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [LEVEL_W-1:0]  lvl;
    logic                busy;
    bit                  typed;
    res_t                want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [APB_AW-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  drbf_in_if  in_ch ();
  drbf_out_if out_ch ();

  display_reveal_backlight_fader_unit #(.TIME_BITS(32)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Local copy of the sequencer state and its register settings.
  logic [31:0]        cfg_shadow [NUM_REGS];
  logic [31:0]        now_ms    = '0;
  logic [31:0]        fade_from = '0;
  logic [31:0]        hold_til  = '0;
  logic [31:0]        draw_at   = '0;
  logic [31:0]        batch_from = '0;
  logic [LEVEL_W-1:0] target_lvl = LEVEL_RST;
  logic [LEVEL_W-1:0] duty_now  = '0;
  logic               lit       = 1'b0;
  logic               fade_run  = 1'b0;
  logic               draw_due  = 1'b0;
  logic               host_owns = 1'b0;
  logic               batch_on  = 1'b0;

  res_t      status_q [$];
  stim_row_t directed_tab [$];
  int        fail_count   = 0;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        reveals_seen = 0;
  int        fade_results = 0;
  int        settings_run = 0;
  int        tx_calm      = 0;

  function automatic int ms_ahead(logic [31:0] a, logic [31:0] b);
    return int'(a - b);
  endfunction

  function automatic void backlight_off();
    fade_run = 1'b0;
    lit      = 1'b0;
    duty_now = '0;
  endfunction

  function automatic void start_reveal();
    backlight_off();
    hold_til  = now_ms + cfg_shadow[REG_HOLD];
    fade_from = now_ms;
    fade_run  = 1'b1;
    lit       = 1'b1;
  endfunction

  function automatic void fade_step();
    logic [31:0]     elapsed;
    longint unsigned t, f, q, f3, q3, lv, num;
    if (!fade_run) return;
    elapsed = now_ms - fade_from;
    t  = elapsed;
    f  = cfg_shadow[REG_FADE];
    lv = target_lvl;
    if (t >= f) begin
      duty_now = target_lvl;
      fade_run = 1'b0;
    end else begin
      q   = f - t;
      f3  = f * f * f;
      q3  = q * q * q;
      num = 2 * lv * (f3 - q3) + f3;
      duty_now = LEVEL_W'(num / (2 * f3));
    end
  endfunction

  function automatic res_t advance_sequencer(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] lvl,
                                             logic busy);
    res_t r;
    logic redrew;
    redrew = 1'b0;
    case (act)
      ACT_TICK: begin
        now_ms = now_ms + 32'd1;
        if (draw_due && ms_ahead(now_ms, draw_at) >= 0) begin
          if (busy) begin
            draw_at = now_ms + cfg_shadow[REG_RETRY];
          end else begin
            draw_due = 1'b0;
            batch_on = 1'b0;
            start_reveal();
            redrew = 1'b1;
          end
        end
        if (host_owns && batch_on && !draw_due &&
            longint'(ms_ahead(now_ms, batch_from)) >= longint'(cfg_shadow[REG_FALLBACK])) begin
          batch_on  = 1'b0;
          host_owns = 1'b0;
          start_reveal();
          redrew = 1'b1;
        end
        fade_step();
      end
      ACT_LIGHT_ON: begin
        lit      = 1'b1;
        duty_now = target_lvl;
      end
      ACT_LIGHT_OFF: backlight_off();
      ACT_SET_LEVEL: begin
        target_lvl = (lvl < cfg_shadow[REG_MIN_BRI][LEVEL_W-1:0]) ?
                     cfg_shadow[REG_MIN_BRI][LEVEL_W-1:0] : lvl;
        if (lit && !fade_run) duty_now = target_lvl;
      end
      ACT_REVEAL: begin
        start_reveal();
        redrew = 1'b1;
      end
      ACT_SCHEDULE: begin
        draw_due = 1'b1;
        draw_at  = now_ms + cfg_shadow[REG_COALESCE];
      end
      ACT_BOOT: begin
        if (!host_owns) begin
          draw_due = 1'b1;
          draw_at  = now_ms + cfg_shadow[REG_BOOT];
        end
      end
      ACT_DEFER: begin
        if (!host_owns) begin
          host_owns = 1'b1;
          draw_due  = 1'b0;
          backlight_off();
        end
      end
      ACT_BATCH_ON: begin
        batch_on   = 1'b1;
        batch_from = now_ms;
      end
      ACT_BATCH_OFF: batch_on = 1'b0;
      ACT_CLR_HOST: begin
        host_owns = 1'b0;
        batch_on  = 1'b0;
      end
      default: ;
    endcase
    r.pwm_duty   = duty_now;
    r.defer_blit = batch_on || draw_due || (ms_ahead(now_ms, hold_til) < 0);
    r.redraw_all = redrew;
    r.fading_now = fade_run;
    r.batch_mode = batch_on;
    r.brightness = target_lvl;
    return r;
  endfunction

  // Mostly no gap or a short one, a few long ones, and now and then a stretch with none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t row(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] lvl,
                                    logic busy, bit typed, logic [LEVEL_W-1:0] duty,
                                    logic defer, logic redraw, logic fading, logic batch,
                                    logic [LEVEL_W-1:0] bri);
    stim_row_t s;
    s.act = act;
    s.lvl = lvl;
    s.busy = busy;
    s.typed = typed;
    s.want.pwm_duty   = duty;
    s.want.defer_blit = defer;
    s.want.redraw_all = redraw;
    s.want.fading_now = fading;
    s.want.batch_mode = batch;
    s.want.brightness = bri;
    return s;
  endfunction

  task automatic send_item(logic [ACTION_W-1:0] act, logic [LEVEL_W-1:0] lvl, logic busy,
                           bit typed, res_t want);
    int   gap;
    res_t predicted;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.level_in      <= lvl;
    in_ch.frame_rx_busy <= busy;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_sequencer(act, lvl, busy);
    status_q.push_back(typed ? want : predicted);
    if (act < ACT_FIRST_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(logic [ACTION_W-1:0] act);
    send_item(act, LEVEL_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
  endtask

  task automatic send_ticks(int n, int busy_pct);
    repeat (n) begin
      send_item(ACT_TICK, LEVEL_W'($urandom_range(0, 255)),
                ($urandom_range(0, 99) < busy_pct), 1'b0, '0);
    end
  endtask

  task automatic send_scenario();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_op(($urandom_range(0, 1) == 0) ? ACT_SCHEDULE : ACT_BOOT);
      send_ticks($urandom_range(1, 50), $urandom_range(0, 60));
    end else if (r < 45) begin
      send_op(ACT_DEFER);
      send_op(ACT_BATCH_ON);
      send_ticks($urandom_range(1, 90), 10);
      if ($urandom_range(0, 2) == 0) send_op(ACT_CLR_HOST);
      else if ($urandom_range(0, 2) == 0) send_op(ACT_BATCH_OFF);
    end else if (r < 62) begin
      send_op(ACT_REVEAL);
      send_ticks($urandom_range(1, 30), 20);
      if ($urandom_range(0, 3) == 0) send_op(ACT_LIGHT_ON);
    end else if (r < 78) begin
      send_op(ACT_SET_LEVEL);
      send_op(($urandom_range(0, 1) == 0) ? ACT_LIGHT_ON : ACT_LIGHT_OFF);
      send_ticks($urandom_range(0, 4), 50);
    end else begin
      send_item(ACTION_W'($urandom_range(0, 15)), LEVEL_W'($urandom_range(0, 255)),
                logic'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  task automatic cfg_write(int idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'(4 * idx);
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  task automatic cfg_read(int idx, output logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= APB_AW'(4 * idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    val = cfg_prdata;
    @(negedge clk);
  endtask

  task automatic check_settings();
    logic [31:0] got;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_read(i, got);
      if (got !== cfg_shadow[i]) begin
        $error("register %0d: expected %0d, got %0d", i, cfg_shadow[i], got);
        fail_count++;
      end
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_settings(logic [31:0] fade, logic [31:0] hold, logic [31:0] boot,
                                  logic [31:0] coalesce, logic [31:0] fallback,
                                  logic [31:0] retry, logic [31:0] min_bri);
    logic [31:0] vals [NUM_REGS];
    vals[REG_FADE]     = fade;
    vals[REG_HOLD]     = hold;
    vals[REG_BOOT]     = boot;
    vals[REG_COALESCE] = coalesce;
    vals[REG_FALLBACK] = fallback;
    vals[REG_RETRY]    = retry;
    vals[REG_MIN_BRI]  = min_bri;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write(i, vals[i]);
      cfg_shadow[i] = vals[i];
    end
    check_settings();
    settings_run++;
  endtask

  task automatic run_random(int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) send_scenario();
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd12_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.redraw_all) reveals_seen++;
      if (out_ch.fading_now) fade_results++;
      if (status_q.size() == 0) begin
        $error("result arrived with no item outstanding");
        fail_count++;
      end else begin
        want = status_q.pop_front();
        if (out_ch.pwm_duty !== want.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_ch.pwm_duty);
          fail_count++;
        end
        if (out_ch.defer_blit !== want.defer_blit) begin
          $error("defer_blit: expected %0d, got %0d", want.defer_blit, out_ch.defer_blit);
          fail_count++;
        end
        if (out_ch.redraw_all !== want.redraw_all) begin
          $error("redraw_all: expected %0d, got %0d", want.redraw_all, out_ch.redraw_all);
          fail_count++;
        end
        if (out_ch.fading_now !== want.fading_now) begin
          $error("fading_now: expected %0d, got %0d", want.fading_now, out_ch.fading_now);
          fail_count++;
        end
        if (out_ch.batch_mode !== want.batch_mode) begin
          $error("batch_mode: expected %0d, got %0d", want.batch_mode, out_ch.batch_mode);
          fail_count++;
        end
        if (out_ch.brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, out_ch.brightness);
          fail_count++;
        end
      end
    end
  end

  // Result side pacing, with one long hold-off so that the block backs up.
  initial begin : rx_pacing
    int  stall;
    int  calm;
    bit  held;
    out_ch.ready = 1'b0;
    stall = 0;
    calm  = 0;
    held  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 200) begin
        held  = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = idle_len(calm);
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : main_flow
    stim_row_t s;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_TICK;
    in_ch.level_in      = '0;
    in_ch.frame_rx_busy = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    cfg_shadow[REG_FADE]     = FADE_RST;
    cfg_shadow[REG_HOLD]     = HOLD_RST;
    cfg_shadow[REG_BOOT]     = BOOT_RST;
    cfg_shadow[REG_COALESCE] = COALESCE_RST;
    cfg_shadow[REG_FALLBACK] = FALLBACK_RST;
    cfg_shadow[REG_RETRY]    = RETRY_RST;
    cfg_shadow[REG_MIN_BRI]  = MIN_BRI_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_settings();

    directed_tab.push_back(row(ACT_TICK,      8'd0,   1'b0, 1, 8'd0,   0, 0, 0, 0, 8'd255));
    directed_tab.push_back(row(ACT_SET_LEVEL, 8'd0,   1'b0, 1, 8'd0,   0, 0, 0, 0, 8'd8));
    directed_tab.push_back(row(ACT_SET_LEVEL, 8'd255, 1'b0, 1, 8'd0,   0, 0, 0, 0, 8'd255));
    directed_tab.push_back(row(ACT_LIGHT_ON,  8'd0,   1'b0, 1, 8'd255, 0, 0, 0, 0, 8'd255));
    directed_tab.push_back(row(ACT_SET_LEVEL, 8'd100, 1'b0, 1, 8'd100, 0, 0, 0, 0, 8'd100));
    directed_tab.push_back(row(ACT_LIGHT_OFF, 8'd0,   1'b0, 1, 8'd0,   0, 0, 0, 0, 8'd100));
    directed_tab.push_back(row(ACT_REVEAL,    8'd0,   1'b0, 1, 8'd0,   1, 1, 1, 0, 8'd100));
    directed_tab.push_back(row(ACT_TICK,      8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_LIGHT_ON,  8'd0,   1'b0, 1, 8'd100, 1, 0, 1, 0, 8'd100));
    directed_tab.push_back(row(ACT_TICK,      8'd255, 1'b1, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_LAST_CODE, 8'd255, 1'b1, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_FIRST_UNUSED, 8'd0, 1'b0, 0, 8'd0,  0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_SCHEDULE,  8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_TICK,      8'd0,   1'b1, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_BOOT,      8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_DEFER,     8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_DEFER,     8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_BOOT,      8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_BATCH_ON,  8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_TICK,      8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_BATCH_OFF, 8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_CLR_HOST,  8'd0,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_SET_LEVEL, 8'd7,   1'b0, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    directed_tab.push_back(row(ACT_TICK,      8'd0,   1'b1, 0, 8'd0,   0, 0, 0, 0, 8'd0));
    foreach (directed_tab[i]) begin
      s = directed_tab[i];
      send_item(s.act, s.lvl, s.busy, s.typed, s.want);
    end
    run_random(60);

    program_settings(0, 0, 0, 0, 0, 0, 0);
    run_random(110);
    program_settings(1023, 65535, 65535, 65535, 65535, 65535, 255);
    run_random(110);
    repeat (9) begin
      program_settings($urandom_range(1, 12), $urandom_range(0, 40), $urandom_range(0, 60),
                       $urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 12),
                       $urandom_range(0, 255));
      run_random(110);
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d items over %0d register settings; %0d results checked.",
             items_sent, settings_run + 1, results_seen);
    $display("Results with a reveal: %0d, results during a fade: %0d.",
             reveals_seen, fade_results);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/drbf_pkg.sv
rtl/drbf_chan_if.sv
rtl/drbf_cfg.sv
rtl/drbf_ctrl.sv
rtl/drbf_dp.sv
rtl/display_reveal_backlight_fader_unit.sv
rtl/drbf_checker.sv
bench/tb_display_reveal_backlight_fader_unit.sv
